@@ rtl/svf_pkg.sv @@
// Shared types, widths and constants of the state variable filter.
package svf_pkg;

   // Fixed-point format and filter constants.
   localparam int FRAC_BITS    = 15;
   localparam int SMOOTH_ALPHA = 983;
   localparam int ONE_Q        = 1 << FRAC_BITS;
   localparam int CLIP_LIM     = 2 << FRAC_BITS;
   localparam int OUT_MAX      = 131071;
   localparam int OUT_MIN      = -131072;

   // Field and datapath widths.
   localparam int MODE_W       = 2;
   localparam int MIX_W        = 16;
   localparam int DRIVE_W      = 17;
   localparam int TGT_W        = 16;
   localparam int COEF_W       = 17;
   localparam int SAMPLE_IN_W  = 17;
   localparam int SAMPLE_OUT_W = 18;
   localparam int X_W          = 18;
   localparam int INTEG_W      = 32;
   localparam int V3_W         = 33;
   localparam int ACC_W        = 40;
   localparam int MUL_A_W      = 18;
   localparam int PROD_W       = MUL_A_W + ACC_W;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 17;
   localparam int NUM_COEF     = 4;
   localparam int NUM_LANES    = 2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIX      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_A1_TGT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_A2_TGT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_A3_TGT   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMP_TGT = 3'd6;

   // Filter responses.
   localparam logic [MODE_W-1:0] MODE_LOW   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HIGH  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BAND  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NOTCH = 2'd3;

   // Coefficient slots.
   localparam logic [1:0] COEF_A1 = 2'd0;
   localparam logic [1:0] COEF_A2 = 2'd1;
   localparam logic [1:0] COEF_A3 = 2'd2;
   localparam logic [1:0] COEF_K  = 2'd3;

   // Register update done by the datapath in a cycle.
   typedef enum logic [3:0] {
      ACT_NONE     = 4'd0,
      ACT_CAPTURE  = 4'd1,
      ACT_LOAD     = 4'd2,
      ACT_GWB_A1   = 4'd3,
      ACT_GWB_A2   = 4'd4,
      ACT_GWB_A3   = 4'd5,
      ACT_GWB_K    = 4'd6,
      ACT_XWB      = 4'd7,
      ACT_ACC1_SET = 4'd8,
      ACT_ACC1_ADD = 4'd9,
      ACT_ACC2_SET = 4'd10,
      ACT_ACC2_ADD = 4'd11,
      ACT_WET      = 4'd12,
      ACT_OUT      = 4'd13,
      ACT_PASS     = 4'd14
   } dp_act_type;

   // Operand pair fed to the shared multiplier in a cycle.
   typedef enum logic [3:0] {
      MOP_NONE  = 4'd0,
      MOP_G_A1  = 4'd1,
      MOP_G_A2  = 4'd2,
      MOP_G_A3  = 4'd3,
      MOP_G_K   = 4'd4,
      MOP_DRIVE = 4'd5,
      MOP_A1_I1 = 4'd6,
      MOP_A2_V3 = 4'd7,
      MOP_A2_I1 = 4'd8,
      MOP_A3_V3 = 4'd9,
      MOP_K_V1  = 4'd10,
      MOP_MIX   = 4'd11
   } mul_op_type;

   typedef struct packed {
      dp_act_type act;
      mul_op_type mop;
   } cmd_type;

   typedef struct packed {
      logic mix_zero;
      logic loaded;
      logic out_free;
   } status_type;

endpackage

@@ rtl/svf_if.sv @@
// Channel interfaces of the state variable filter: sample request, result and register write.
interface svf_req_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    lane;
   logic signed [svf_pkg::SAMPLE_IN_W-1:0]  sample_in;

   modport source(output valid, output lane, output sample_in, input ready);
   modport sink(input valid, input lane, input sample_in, output ready);
endinterface

interface svf_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [svf_pkg::SAMPLE_OUT_W-1:0] sample_out;

   modport source(output valid, output sample_out, input ready);
   modport sink(input valid, input sample_out, output ready);
endinterface

interface svf_csr_if;
   logic                              valid;
   logic                              ready;
   logic [svf_pkg::CSR_IDX_W-1:0]     index;
   logic [svf_pkg::CSR_DATA_W-1:0]    data;

   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

@@ rtl/svf_ctrl.sv @@
// Sequencer of the filter: steps the shared multiplier and register updates for each sample.
module svf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  svf_pkg::status_type status,
   output svf_pkg::cmd_type    cmd
);

   typedef enum logic [15:0] {
      ST_IDLE = 16'b0000_0000_0000_0001,
      ST_LOAD = 16'b0000_0000_0000_0010,
      ST_G1   = 16'b0000_0000_0000_0100,
      ST_G2   = 16'b0000_0000_0000_1000,
      ST_G3   = 16'b0000_0000_0001_0000,
      ST_G4   = 16'b0000_0000_0010_0000,
      ST_DRV  = 16'b0000_0000_0100_0000,
      ST_XC   = 16'b0000_0000_1000_0000,
      ST_M2   = 16'b0000_0001_0000_0000,
      ST_M3   = 16'b0000_0010_0000_0000,
      ST_M4   = 16'b0000_0100_0000_0000,
      ST_M5   = 16'b0000_1000_0000_0000,
      ST_WET  = 16'b0001_0000_0000_0000,
      ST_MIX  = 16'b0010_0000_0000_0000,
      ST_OUT  = 16'b0100_0000_0000_0000,
      ST_PASS = 16'b1000_0000_0000_0000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           glide_run_ff, glide_run_in;

   always_comb begin
      state_in     = state_ff;
      glide_run_in = glide_run_ff;
      cmd.act      = svf_pkg::ACT_NONE;
      cmd.mop      = svf_pkg::MOP_NONE;
      req_ready    = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.act      = svf_pkg::ACT_CAPTURE;
               glide_run_in = status.loaded;
               if (status.mix_zero) begin
                  state_in = ST_PASS;
               end else if (status.loaded) begin
                  state_in = ST_G1;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            cmd.act  = svf_pkg::ACT_LOAD;
            state_in = ST_DRV;
         end
         // Each glide product is written back in the cycle after it is issued.
         ST_G1: begin
            cmd.mop  = svf_pkg::MOP_G_A1;
            state_in = ST_G2;
         end
         ST_G2: begin
            cmd.act  = svf_pkg::ACT_GWB_A1;
            cmd.mop  = svf_pkg::MOP_G_A2;
            state_in = ST_G3;
         end
         ST_G3: begin
            cmd.act  = svf_pkg::ACT_GWB_A2;
            cmd.mop  = svf_pkg::MOP_G_A3;
            state_in = ST_G4;
         end
         ST_G4: begin
            cmd.act  = svf_pkg::ACT_GWB_A3;
            cmd.mop  = svf_pkg::MOP_G_K;
            state_in = ST_DRV;
         end
         ST_DRV: begin
            cmd.act  = glide_run_ff ? svf_pkg::ACT_GWB_K : svf_pkg::ACT_NONE;
            cmd.mop  = svf_pkg::MOP_DRIVE;
            state_in = ST_XC;
         end
         ST_XC: begin
            cmd.act  = svf_pkg::ACT_XWB;
            cmd.mop  = svf_pkg::MOP_A1_I1;
            state_in = ST_M2;
         end
         ST_M2: begin
            cmd.act  = svf_pkg::ACT_ACC1_SET;
            cmd.mop  = svf_pkg::MOP_A2_V3;
            state_in = ST_M3;
         end
         ST_M3: begin
            cmd.act  = svf_pkg::ACT_ACC1_ADD;
            cmd.mop  = svf_pkg::MOP_A2_I1;
            state_in = ST_M4;
         end
         ST_M4: begin
            cmd.act  = svf_pkg::ACT_ACC2_SET;
            cmd.mop  = svf_pkg::MOP_A3_V3;
            state_in = ST_M5;
         end
         ST_M5: begin
            cmd.act  = svf_pkg::ACT_ACC2_ADD;
            cmd.mop  = svf_pkg::MOP_K_V1;
            state_in = ST_WET;
         end
         ST_WET: begin
            cmd.act  = svf_pkg::ACT_WET;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            cmd.mop  = svf_pkg::MOP_MIX;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.act  = svf_pkg::ACT_OUT;
               state_in = ST_IDLE;
            end
         end
         ST_PASS: begin
            if (status.out_free) begin
               cmd.act  = svf_pkg::ACT_PASS;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         glide_run_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         glide_run_ff <= glide_run_in;
      end
   end

endmodule

@@ rtl/svf_dp.sv @@
// Datapath of the filter: registers, coefficients, integrators and the shared multiplier.
module svf_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  svf_pkg::cmd_type                       cmd,
   output svf_pkg::status_type                    status,
   input  logic                                   req_lane,
   input  logic signed [svf_pkg::SAMPLE_IN_W-1:0] req_sample_in,
   input  logic                                   csr_valid,
   input  logic [svf_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [svf_pkg::CSR_DATA_W-1:0]         csr_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [svf_pkg::SAMPLE_OUT_W-1:0] rsp_sample_out
);

   localparam int ACC_W   = svf_pkg::ACC_W;
   localparam int RES_W   = ACC_W + 1;
   localparam int COEF_W  = svf_pkg::COEF_W;
   localparam int INTEG_W = svf_pkg::INTEG_W;

   // Configuration registers.
   logic [svf_pkg::MODE_W-1:0]  mode_ff, mode_in;
   logic [svf_pkg::MIX_W-1:0]   mix_ff, mix_in;
   logic [svf_pkg::DRIVE_W-1:0] drive_ff, drive_in;
   logic [svf_pkg::TGT_W-1:0]   tgt_ff [svf_pkg::NUM_COEF];
   logic [svf_pkg::TGT_W-1:0]   tgt_in [svf_pkg::NUM_COEF];

   // Filter state.
   logic signed [COEF_W-1:0]  coef_ff [svf_pkg::NUM_COEF];
   logic signed [COEF_W-1:0]  coef_in [svf_pkg::NUM_COEF];
   logic                      loaded_ff, loaded_in;
   logic signed [INTEG_W-1:0] integ1_ff [svf_pkg::NUM_LANES];
   logic signed [INTEG_W-1:0] integ1_in [svf_pkg::NUM_LANES];
   logic signed [INTEG_W-1:0] integ2_ff [svf_pkg::NUM_LANES];
   logic signed [INTEG_W-1:0] integ2_in [svf_pkg::NUM_LANES];

   // Per-sample working registers.
   logic                               lane_ff, lane_in;
   logic signed [svf_pkg::X_W-1:0]     x_ff, x_in;
   logic signed [INTEG_W-1:0]          i1_ff, i1_in, i2_ff, i2_in;
   logic signed [svf_pkg::V3_W-1:0]    v3_ff, v3_in;
   logic signed [ACC_W-1:0]            acc1_ff, acc1_in, acc2_ff, acc2_in;
   logic signed [ACC_W-1:0]            d_ff, d_in;
   logic signed [ACC_W-1:0]            p_ff, p_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [svf_pkg::SAMPLE_OUT_W-1:0] rsp_data_ff, rsp_data_in;

   // Combinational helpers.
   logic signed [svf_pkg::MUL_A_W-1:0] mul_a;
   logic signed [ACC_W-1:0]            mul_b;
   logic signed [svf_pkg::PROD_W-1:0]  prod;
   logic [1:0]                         gsel, wsel;
   logic                               gwb;
   logic signed [ACC_W-1:0]            gdiff;
   logic signed [ACC_W-1:0]            xc;
   logic signed [RES_W-1:0]            res;
   logic                               drive_on;

   assign drive_on = (drive_ff != svf_pkg::DRIVE_W'(svf_pkg::ONE_Q));

   assign status.mix_zero = (mix_ff == '0);
   assign status.loaded   = loaded_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   // Shared multiplier: operand selection, full product, floor shift by the fraction bits.
   always_comb begin
      gsel = svf_pkg::COEF_A1;
      unique case (cmd.mop)
         svf_pkg::MOP_G_A2: gsel = svf_pkg::COEF_A2;
         svf_pkg::MOP_G_A3: gsel = svf_pkg::COEF_A3;
         svf_pkg::MOP_G_K:  gsel = svf_pkg::COEF_K;
         default:           gsel = svf_pkg::COEF_A1;
      endcase
      gdiff = ACC_W'($signed({1'b0, tgt_ff[gsel]})) - ACC_W'(coef_ff[gsel]);

      mul_a = '0;
      mul_b = '0;
      unique case (cmd.mop)
         svf_pkg::MOP_NONE: begin
            mul_a = '0;
            mul_b = '0;
         end
         svf_pkg::MOP_G_A1, svf_pkg::MOP_G_A2, svf_pkg::MOP_G_A3, svf_pkg::MOP_G_K: begin
            mul_a = svf_pkg::MUL_A_W'(svf_pkg::SMOOTH_ALPHA);
            mul_b = gdiff;
         end
         svf_pkg::MOP_DRIVE: begin
            mul_a = $signed({1'b0, drive_ff});
            mul_b = ACC_W'(x_ff);
         end
         svf_pkg::MOP_A1_I1: begin
            mul_a = svf_pkg::MUL_A_W'(coef_ff[svf_pkg::COEF_A1]);
            mul_b = ACC_W'(i1_ff);
         end
         svf_pkg::MOP_A2_V3: begin
            mul_a = svf_pkg::MUL_A_W'(coef_ff[svf_pkg::COEF_A2]);
            mul_b = ACC_W'(v3_ff);
         end
         svf_pkg::MOP_A2_I1: begin
            mul_a = svf_pkg::MUL_A_W'(coef_ff[svf_pkg::COEF_A2]);
            mul_b = ACC_W'(i1_ff);
         end
         svf_pkg::MOP_A3_V3: begin
            mul_a = svf_pkg::MUL_A_W'(coef_ff[svf_pkg::COEF_A3]);
            mul_b = ACC_W'(v3_ff);
         end
         svf_pkg::MOP_K_V1: begin
            mul_a = svf_pkg::MUL_A_W'(coef_ff[svf_pkg::COEF_K]);
            mul_b = acc1_ff;
         end
         svf_pkg::MOP_MIX: begin
            mul_a = $signed({2'b00, mix_ff});
            mul_b = d_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod = mul_a * mul_b;
   end

   // Register updates.
   always_comb begin
      mode_in      = mode_ff;
      mix_in       = mix_ff;
      drive_in     = drive_ff;
      tgt_in       = tgt_ff;
      coef_in      = coef_ff;
      loaded_in    = loaded_ff;
      integ1_in    = integ1_ff;
      integ2_in    = integ2_ff;
      lane_in      = lane_ff;
      x_in         = x_ff;
      i1_in        = i1_ff;
      i2_in        = i2_ff;
      v3_in        = v3_ff;
      acc1_in      = acc1_ff;
      acc2_in      = acc2_ff;
      d_in         = d_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      // The product register holds through cycles that issue no multiply.
      p_in         = (cmd.mop == svf_pkg::MOP_NONE) ? p_ff
                                                   : prod[svf_pkg::FRAC_BITS +: ACC_W];

      if (csr_valid) begin
         unique case (csr_index)
            svf_pkg::CSR_MODE: begin
               mode_in   = csr_data[svf_pkg::MODE_W-1:0];
               loaded_in = 1'b0;
               for (int l = 0; l < svf_pkg::NUM_LANES; l++) begin
                  integ1_in[l] = '0;
                  integ2_in[l] = '0;
               end
            end
            svf_pkg::CSR_MIX:      mix_in   = csr_data[svf_pkg::MIX_W-1:0];
            svf_pkg::CSR_DRIVE:    drive_in = csr_data[svf_pkg::DRIVE_W-1:0];
            svf_pkg::CSR_A1_TGT:   tgt_in[svf_pkg::COEF_A1] = csr_data[svf_pkg::TGT_W-1:0];
            svf_pkg::CSR_A2_TGT:   tgt_in[svf_pkg::COEF_A2] = csr_data[svf_pkg::TGT_W-1:0];
            svf_pkg::CSR_A3_TGT:   tgt_in[svf_pkg::COEF_A3] = csr_data[svf_pkg::TGT_W-1:0];
            svf_pkg::CSR_DAMP_TGT: tgt_in[svf_pkg::COEF_K]  = csr_data[svf_pkg::TGT_W-1:0];
            default: begin
            end
         endcase
      end

      // Glide write-back: snap to the target when the step truncates to zero.
      gwb  = 1'b0;
      wsel = svf_pkg::COEF_A1;
      unique case (cmd.act)
         svf_pkg::ACT_GWB_A1: begin gwb = 1'b1; wsel = svf_pkg::COEF_A1; end
         svf_pkg::ACT_GWB_A2: begin gwb = 1'b1; wsel = svf_pkg::COEF_A2; end
         svf_pkg::ACT_GWB_A3: begin gwb = 1'b1; wsel = svf_pkg::COEF_A3; end
         svf_pkg::ACT_GWB_K:  begin gwb = 1'b1; wsel = svf_pkg::COEF_K;  end
         default: begin
            gwb  = 1'b0;
            wsel = svf_pkg::COEF_A1;
         end
      endcase
      if (gwb) begin
         if (p_ff == '0 && coef_ff[wsel] != $signed({1'b0, tgt_ff[wsel]})) begin
            coef_in[wsel] = $signed({1'b0, tgt_ff[wsel]});
         end else begin
            coef_in[wsel] = coef_ff[wsel] + p_ff[COEF_W-1:0];
         end
      end

      xc = drive_on ? ((p_ff > ACC_W'(svf_pkg::CLIP_LIM)) ? ACC_W'(svf_pkg::CLIP_LIM) :
                       (p_ff < -ACC_W'(svf_pkg::CLIP_LIM)) ? -ACC_W'(svf_pkg::CLIP_LIM) : p_ff)
                    : ACC_W'(x_ff);
      res = RES_W'(x_ff) + RES_W'(p_ff);

      unique case (cmd.act)
         svf_pkg::ACT_CAPTURE: begin
            lane_in = req_lane;
            x_in    = svf_pkg::X_W'(req_sample_in);
            i1_in   = integ1_ff[req_lane];
            i2_in   = integ2_ff[req_lane];
         end
         svf_pkg::ACT_LOAD: begin
            loaded_in = 1'b1;
            for (int c = 0; c < svf_pkg::NUM_COEF; c++) begin
               coef_in[c] = $signed({1'b0, tgt_ff[c]});
            end
         end
         svf_pkg::ACT_XWB: begin
            x_in  = xc[svf_pkg::X_W-1:0];
            v3_in = svf_pkg::V3_W'(xc) - svf_pkg::V3_W'(i2_ff);
         end
         svf_pkg::ACT_ACC1_SET: acc1_in = p_ff;
         svf_pkg::ACT_ACC1_ADD: acc1_in = acc1_ff + p_ff;
         svf_pkg::ACT_ACC2_SET: acc2_in = ACC_W'(i2_ff) + p_ff;
         svf_pkg::ACT_ACC2_ADD: begin
            acc2_in            = acc2_ff + p_ff;
            integ1_in[lane_ff] = {acc1_ff[INTEG_W-2:0], 1'b0} - i1_ff;
         end
         svf_pkg::ACT_WET: begin
            // Wet response minus the dry sample, ready for the blend multiply.
            unique case (mode_ff)
               svf_pkg::MODE_LOW:   d_in = acc2_ff - ACC_W'(x_ff);
               svf_pkg::MODE_HIGH:  d_in = -(p_ff + acc2_ff);
               svf_pkg::MODE_BAND:  d_in = acc1_ff - ACC_W'(x_ff);
               svf_pkg::MODE_NOTCH: d_in = -p_ff;
               default:             d_in = acc2_ff - ACC_W'(x_ff);
            endcase
            integ2_in[lane_ff] = {acc2_ff[INTEG_W-2:0], 1'b0} - i2_ff;
         end
         svf_pkg::ACT_OUT: begin
            rsp_valid_in = 1'b1;
            if (res > RES_W'(svf_pkg::OUT_MAX)) begin
               rsp_data_in = svf_pkg::SAMPLE_OUT_W'(svf_pkg::OUT_MAX);
            end else if (res < RES_W'(svf_pkg::OUT_MIN)) begin
               rsp_data_in = svf_pkg::SAMPLE_OUT_W'(svf_pkg::OUT_MIN);
            end else begin
               rsp_data_in = res[svf_pkg::SAMPLE_OUT_W-1:0];
            end
         end
         svf_pkg::ACT_PASS: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = x_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff                    <= svf_pkg::MODE_LOW;
         mix_ff                     <= '0;
         drive_ff                   <= svf_pkg::DRIVE_W'(svf_pkg::ONE_Q);
         tgt_ff[svf_pkg::COEF_A1]   <= svf_pkg::TGT_W'(svf_pkg::ONE_Q);
         tgt_ff[svf_pkg::COEF_A2]   <= '0;
         tgt_ff[svf_pkg::COEF_A3]   <= '0;
         tgt_ff[svf_pkg::COEF_K]    <= svf_pkg::TGT_W'(svf_pkg::ONE_Q);
         coef_ff[svf_pkg::COEF_A1]  <= COEF_W'(svf_pkg::ONE_Q);
         coef_ff[svf_pkg::COEF_A2]  <= '0;
         coef_ff[svf_pkg::COEF_A3]  <= '0;
         coef_ff[svf_pkg::COEF_K]   <= COEF_W'(svf_pkg::ONE_Q);
         loaded_ff                  <= 1'b0;
         for (int l = 0; l < svf_pkg::NUM_LANES; l++) begin
            integ1_ff[l] <= '0;
            integ2_ff[l] <= '0;
         end
         rsp_valid_ff               <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         mix_ff       <= mix_in;
         drive_ff     <= drive_in;
         tgt_ff       <= tgt_in;
         coef_ff      <= coef_in;
         loaded_ff    <= loaded_in;
         integ1_ff    <= integ1_in;
         integ2_ff    <= integ2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff     <= lane_in;
      x_ff        <= x_in;
      i1_ff       <= i1_in;
      i2_ff       <= i2_in;
      v3_ff       <= v3_in;
      acc1_ff     <= acc1_in;
      acc2_ff     <= acc2_in;
      d_ff        <= d_in;
      p_ff        <= p_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ rtl/tpt_state_variable_filter.sv @@
// Each filtered sample first glides the coefficients, or loads them directly after a snap (mode
// write or reset); the sample passes straight through when mix_amount is zero. One sample is in
// work at a time. All products come from the single shared 18x40 multiplier, which gives
// one product per cycle. A result waiting in the output register does not block the next beat.
// Synchronous active-high reset clears the integrators, loads default registers and coefficients
// and arms a coefficient snap on the next filtered sample.
module tpt_state_variable_filter (
   input logic        clock,
   input logic        reset,
   svf_req_if.sink    req_if,
   svf_rsp_if.source  rsp_if,
   svf_csr_if.sink    csr_if
);

   svf_pkg::cmd_type    cmd;
   svf_pkg::status_type status;

   assign csr_if.ready = 1'b1;

   svf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   svf_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_lane       (req_if.lane),
      .req_sample_in  (req_if.sample_in),
      .csr_valid      (csr_if.valid),
      .csr_index      (csr_if.index),
      .csr_data       (csr_if.data),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_sample_out (rsp_if.sample_out)
   );

endmodule

@@ rtl/svf_checker.sv @@
// Port-level checks of the filter and the bind that attaches them to the top level.
module svf_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_ready,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic signed [svf_pkg::SAMPLE_OUT_W-1:0] rsp_sample_out
);

   // Samples taken in but not yet delivered.
   logic [1:0] pending_ff, pending_in;

   always_comb begin
      pending_in = pending_ff + 2'((req_valid && req_ready) ? 1 : 0)
                              - 2'((rsp_valid && rsp_ready) ? 1 : 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_sample_out))
      else $error("result changed while stalled");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result beat without a sample in work");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 2'd2 |-> !req_ready)
      else $error("request taken with a result waiting and a sample in work");

endmodule

bind tpt_state_variable_filter svf_checker u_svf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_sample_out (rsp_if.sample_out)
);

@@ tb/tpt_state_variable_filter_tb.sv @@
// Self-checking testbench for the stereo state variable filter with a behavioral predictor.
module tpt_state_variable_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Index past the end of the register list; the block must ignore it.
   localparam logic [svf_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   logic clock = 1'b0;
   logic reset;

   svf_req_if req_bus();
   svf_rsp_if rsp_bus();
   svf_csr_if csr_bus();

   tpt_state_variable_filter dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor copy of the registers and the filter state.
   logic [svf_pkg::MODE_W-1:0]          cfg_mode  = svf_pkg::MODE_LOW;
   logic [svf_pkg::MIX_W-1:0]           cfg_mix   = '0;
   logic [svf_pkg::DRIVE_W-1:0]         cfg_drive = svf_pkg::DRIVE_W'(svf_pkg::ONE_Q);
   longint tgt_a1 = svf_pkg::ONE_Q, tgt_a2 = 0, tgt_a3 = 0, tgt_k = svf_pkg::ONE_Q;
   longint cur_a1 = svf_pkg::ONE_Q, cur_a2 = 0, cur_a3 = 0, cur_k = svf_pkg::ONE_Q;
   logic                                coef_loaded = 1'b0;
   logic signed [svf_pkg::INTEG_W-1:0]  integ_a [svf_pkg::NUM_LANES] = '{default: '0};
   logic signed [svf_pkg::INTEG_W-1:0]  integ_b [svf_pkg::NUM_LANES] = '{default: '0};

   logic signed [svf_pkg::SAMPLE_OUT_W-1:0] pending_out[$];
   int unsigned mismatch_count = 0;
   bit          no_gaps = 1'b0;

   function automatic longint qmul(longint a, longint b);
      return (a * b) >>> svf_pkg::FRAC_BITS;
   endfunction

   function automatic longint glide_coef(longint cur, longint tgt);
      longint step;
      step = qmul(svf_pkg::SMOOTH_ALPHA, tgt - cur);
      if (step == 0 && cur != tgt)
         return tgt;
      return cur + step;
   endfunction

   function automatic void apply_reg_write(logic [svf_pkg::CSR_IDX_W-1:0] idx,
                                           logic [svf_pkg::CSR_DATA_W-1:0] value);
      case (idx)
         svf_pkg::CSR_MODE: begin
            cfg_mode = value[svf_pkg::MODE_W-1:0];
            integ_a = '{default: '0};
            integ_b = '{default: '0};
            coef_loaded = 1'b0;
         end
         svf_pkg::CSR_MIX:      cfg_mix = value[svf_pkg::MIX_W-1:0];
         svf_pkg::CSR_DRIVE:    cfg_drive = value[svf_pkg::DRIVE_W-1:0];
         svf_pkg::CSR_A1_TGT:   tgt_a1 = longint'(value[svf_pkg::TGT_W-1:0]);
         svf_pkg::CSR_A2_TGT:   tgt_a2 = longint'(value[svf_pkg::TGT_W-1:0]);
         svf_pkg::CSR_A3_TGT:   tgt_a3 = longint'(value[svf_pkg::TGT_W-1:0]);
         svf_pkg::CSR_DAMP_TGT: tgt_k = longint'(value[svf_pkg::TGT_W-1:0]);
         default: ;
      endcase
   endfunction

   // Runs one sample through the predicted filter and returns the expected output.
   function automatic logic signed [svf_pkg::SAMPLE_OUT_W-1:0] filter_sample(
         logic lane, logic signed [svf_pkg::SAMPLE_IN_W-1:0] smp);
      longint x, i1, i2, v1, v2, v3, wet, res, nxt;
      x = smp;
      if (cfg_mix == 0)
         return x[svf_pkg::SAMPLE_OUT_W-1:0];
      if (!coef_loaded) begin
         cur_a1 = tgt_a1;
         cur_a2 = tgt_a2;
         cur_a3 = tgt_a3;
         cur_k  = tgt_k;
         coef_loaded = 1'b1;
      end else begin
         cur_a1 = glide_coef(cur_a1, tgt_a1);
         cur_a2 = glide_coef(cur_a2, tgt_a2);
         cur_a3 = glide_coef(cur_a3, tgt_a3);
         cur_k  = glide_coef(cur_k, tgt_k);
      end
      if (cfg_drive != svf_pkg::ONE_Q) begin
         x = qmul(x, longint'(cfg_drive));
         if (x > svf_pkg::CLIP_LIM) x = svf_pkg::CLIP_LIM;
         else if (x < -svf_pkg::CLIP_LIM) x = -svf_pkg::CLIP_LIM;
      end
      i1 = integ_a[lane];
      i2 = integ_b[lane];
      v3 = x - i2;
      v1 = qmul(cur_a1, i1) + qmul(cur_a2, v3);
      v2 = i2 + qmul(cur_a2, i1) + qmul(cur_a3, v3);
      nxt = 2 * v1 - i1;
      integ_a[lane] = nxt[svf_pkg::INTEG_W-1:0];
      nxt = 2 * v2 - i2;
      integ_b[lane] = nxt[svf_pkg::INTEG_W-1:0];
      case (cfg_mode)
         svf_pkg::MODE_HIGH:  wet = x - qmul(cur_k, v1) - v2;
         svf_pkg::MODE_BAND:  wet = v1;
         svf_pkg::MODE_NOTCH: wet = x - qmul(cur_k, v1);
         default:             wet = v2;
      endcase
      res = x + qmul(wet - x, longint'(cfg_mix));
      if (res > svf_pkg::OUT_MAX) res = svf_pkg::OUT_MAX;
      if (res < svf_pkg::OUT_MIN) res = svf_pkg::OUT_MIN;
      return res[svf_pkg::SAMPLE_OUT_W-1:0];
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [svf_pkg::SAMPLE_IN_W-1:0] pick_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         case ($urandom_range(0, 3))
            0: return -17'sd65536;
            1: return 17'sd65535;
            2: return '0;
            default: return '1;
         endcase
      end
      if (r < 40)
         return svf_pkg::SAMPLE_IN_W'($urandom_range(0, 4000))
                - svf_pkg::SAMPLE_IN_W'(2000);
      return svf_pkg::SAMPLE_IN_W'($urandom);
   endfunction

   task automatic send_sample(input logic lane,
                              input logic signed [svf_pkg::SAMPLE_IN_W-1:0] smp);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.lane      <= lane;
      req_bus.sample_in <= smp;
      do @(posedge clock); while (!req_bus.ready);
      pending_out.push_back(filter_sample(lane, smp));
   endtask

   // Stops the sender and waits until every expected result has come back.
   task automatic settle_filter();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [svf_pkg::CSR_IDX_W-1:0] idx, input longint value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= svf_pkg::CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_bus.ready);
      apply_reg_write(idx, svf_pkg::CSR_DATA_W'(value));
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Targets of a stable filter for prewarped gain g and damping k, both Q15.
   task automatic write_filter_targets(input longint g, input longint k);
      longint a1, a2, a3;
      a1 = (longint'(1) << 30)
           / (svf_pkg::ONE_Q + ((g * (g + k)) >>> svf_pkg::FRAC_BITS));
      a2 = (g * a1) >>> svf_pkg::FRAC_BITS;
      a3 = (g * a2) >>> svf_pkg::FRAC_BITS;
      write_reg(svf_pkg::CSR_A1_TGT, a1 & 16'hFFFF);
      write_reg(svf_pkg::CSR_A2_TGT, a2 & 16'hFFFF);
      write_reg(svf_pkg::CSR_A3_TGT, a3 & 16'hFFFF);
      write_reg(svf_pkg::CSR_DAMP_TGT, k & 16'hFFFF);
   endtask

   task automatic test_bypass();
      send_sample(1'b0, -17'sd65536);
      send_sample(1'b1, 17'sd65535);
      send_sample(1'b0, -17'sd1);
      send_sample(1'b1, 17'sd0);
   endtask

   task automatic test_responses();
      logic [svf_pkg::MODE_W-1:0] modes[4];
      modes = '{svf_pkg::MODE_LOW, svf_pkg::MODE_HIGH, svf_pkg::MODE_BAND,
                svf_pkg::MODE_NOTCH};
      settle_filter();
      write_reg(svf_pkg::CSR_MIX, svf_pkg::ONE_Q);
      write_filter_targets(8192, 23170);
      foreach (modes[m]) begin
         settle_filter();
         write_reg(svf_pkg::CSR_MODE, modes[m]);
         send_sample(1'b0, 17'sd65535);
         send_sample(1'b1, -17'sd65536);
         send_sample(1'b0, 17'sd12345);
      end
      // Rewriting the same mode still clears the integrators.
      settle_filter();
      write_reg(svf_pkg::CSR_MODE, svf_pkg::MODE_NOTCH);
      send_sample(1'b1, 17'sd30000);
   endtask

   task automatic test_drive_clip();
      settle_filter();
      write_reg(svf_pkg::CSR_MODE, svf_pkg::MODE_LOW);
      write_reg(svf_pkg::CSR_DRIVE, 131071);
      send_sample(1'b0, 17'sd65535);
      send_sample(1'b1, -17'sd65536);
      settle_filter();
      write_reg(svf_pkg::CSR_DRIVE, 0);
      send_sample(1'b0, 17'sd40000);
      settle_filter();
      write_reg(svf_pkg::CSR_DRIVE, 16384);
      send_sample(1'b1, -17'sd30000);
   endtask

   task automatic test_register_edges();
      settle_filter();
      write_reg(svf_pkg::CSR_DRIVE, svf_pkg::ONE_Q);
      write_reg(svf_pkg::CSR_MIX, 65535);
      write_reg(svf_pkg::CSR_A1_TGT, 65535);
      write_reg(svf_pkg::CSR_A2_TGT, 65535);
      write_reg(svf_pkg::CSR_A3_TGT, 65535);
      write_reg(svf_pkg::CSR_DAMP_TGT, 65535);
      write_reg(CSR_UNUSED, 17'h1ABCD);
      send_sample(1'b0, 17'sd20000);
      // Two new A1 targets far from the coefficient; each sample glides it a step toward the target.
      settle_filter();
      write_reg(svf_pkg::CSR_MIX, svf_pkg::ONE_Q);
      write_reg(svf_pkg::CSR_A1_TGT, 1000);
      send_sample(1'b1, 17'sd5000);
      settle_filter();
      write_reg(svf_pkg::CSR_A1_TGT, 1010);
      send_sample(1'b1, -17'sd5000);
   endtask

   task automatic randomize_registers(input bit write_all);
      int r;
      if (write_all || $urandom_range(0, 2) == 0)
         write_reg(svf_pkg::CSR_MODE, $urandom_range(0, 3));
      if (write_all || $urandom_range(0, 1) == 0) begin
         r = $urandom_range(0, 99);
         if (r < 8) write_reg(svf_pkg::CSR_MIX, 0);
         else if (r < 48) write_reg(svf_pkg::CSR_MIX, svf_pkg::ONE_Q);
         else if (r < 56)
            write_reg(svf_pkg::CSR_MIX, $urandom_range(svf_pkg::ONE_Q + 1, 65535));
         else write_reg(svf_pkg::CSR_MIX, $urandom_range(1, svf_pkg::ONE_Q - 1));
      end
      if (write_all || $urandom_range(0, 1) == 0) begin
         r = $urandom_range(0, 99);
         if (r < 60) write_reg(svf_pkg::CSR_DRIVE, svf_pkg::ONE_Q);
         else if (r < 80) write_reg(svf_pkg::CSR_DRIVE, $urandom_range(0, 131071));
         else if (r < 90) write_reg(svf_pkg::CSR_DRIVE, 131071);
         else write_reg(svf_pkg::CSR_DRIVE, $urandom_range(0, 65535));
      end
      r = $urandom_range(0, 99);
      if (write_all || r < 50) begin
         write_filter_targets($urandom_range(200, 80000), $urandom_range(1000, 65535));
      end else if (r < 70) begin
         write_reg(svf_pkg::CSR_A1_TGT, $urandom_range(0, 65535));
         write_reg(svf_pkg::CSR_A2_TGT, $urandom_range(0, 65535));
         write_reg(svf_pkg::CSR_A3_TGT, $urandom_range(0, 65535));
         write_reg(svf_pkg::CSR_DAMP_TGT, $urandom_range(0, 65535));
      end else if (r < 85) begin
         // Nudge the targets so the coefficients glide a little or snap.
         write_reg(svf_pkg::CSR_A1_TGT, (tgt_a1 + $urandom_range(0, 80) - 40) & 16'hFFFF);
         write_reg(svf_pkg::CSR_A2_TGT, (tgt_a2 + $urandom_range(0, 80) - 40) & 16'hFFFF);
         write_reg(svf_pkg::CSR_A3_TGT, (tgt_a3 + $urandom_range(0, 80) - 40) & 16'hFFFF);
         write_reg(svf_pkg::CSR_DAMP_TGT, (tgt_k + $urandom_range(0, 80) - 40) & 16'hFFFF);
      end
   endtask

   task automatic test_random_traffic();
      int n_items;
      for (int phase = 0; phase < 28; phase++) begin
         settle_filter();
         randomize_registers(phase == 0);
         no_gaps = ($urandom_range(0, 3) == 0);
         n_items = $urandom_range(30, 70);
         for (int i = 0; i < n_items; i++) begin
            if (phase == 14 && i == n_items / 2)
               settle_filter();
            send_sample(1'($urandom), pick_sample());
         end
      end
      no_gaps = 1'b0;
   endtask

   // Result side: random backpressure in bursts.
   initial begin
      int run_len, stall_len;
      rsp_bus.ready = 1'b0;
      forever begin
         run_len = $urandom_range(1, 40);
         repeat (run_len) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b1;
         end
         stall_len = pick_gap();
         repeat (stall_len) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      logic signed [svf_pkg::SAMPLE_OUT_W-1:0] want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_out.size() == 0) begin
            $display("%0t: unexpected result beat, actual %0d", $time, rsp_bus.sample_out);
            mismatch_count++;
         end else begin
            want = pending_out.pop_front();
            if (rsp_bus.sample_out !== want) begin
               $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                        $time, want, rsp_bus.sample_out);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.lane      = 1'b0;
      req_bus.sample_in = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = svf_pkg::CSR_MODE;
      csr_bus.data      = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_bypass();
      test_responses();
      test_drive_clip();
      test_register_edges();
      test_random_traffic();

      settle_filter();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
